FILE: rtl/chmt_pkg.sv
// ----------------------------------------------------------------------------
// chmt_pkg
// Shared constants, codes and types of the convex hull membership test unit.
// ----------------------------------------------------------------------------
package chmt_pkg;

    localparam int MAX_FACETS_DEF = 16;
    localparam int MAX_DIM_DEF    = 4;
    localparam int COORD_BITS_DEF = 16;

    localparam int OFS_W  = 35;
    localparam int DIST_W = 34;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [1:0] OP_NORMAL = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] REG_DIMENSION   = 2'd0;
    localparam logic [1:0] REG_FACET_COUNT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;
    localparam logic [1:0] REG_REPORT_DIST = 2'd3;

    localparam logic [2:0] DIMENSION_RST   = 3'd3;
    localparam logic [4:0] FACET_COUNT_RST = 5'd16;
    localparam logic [7:0] TOLERANCE_RST   = 8'd2;
    localparam logic       REPORT_DIST_RST = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
        logic query;
    } chmt_ctl_t;

    function automatic int sum_width(input int coord_bits);
        int w;
        w = 2 * coord_bits + 2;
        return (w > 64) ? 64 : w;
    endfunction

    function automatic int exc_width(input int coord_bits);
        int s;
        int m;
        s = sum_width(coord_bits);
        m = (s > OFS_W) ? s : OFS_W;
        return (m + 1 > 64) ? 64 : m + 1;
    endfunction

endpackage

FILE: rtl/chmt_dot.sv
// ----------------------------------------------------------------------------
// chmt_dot
// Three-stage facet pipeline: per-coordinate products, product sum, and
// excess over the facet offset. One facet enters per cycle.
// ----------------------------------------------------------------------------
module chmt_dot
    import chmt_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SUM_W     = sum_width(COORD_BITS),
    localparam int EXC_W     = exc_width(COORD_BITS)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  chmt_ctl_t                         in_ctl,
    input  logic [MAX_DIM*COORD_BITS-1:0]     normal,
    input  logic [MAX_DIM*COORD_BITS-1:0]     vec,
    input  logic signed [OFS_W-1:0]           offset,
    input  logic [MAX_DIM-1:0]                dim_mask,
    output chmt_ctl_t                         sum_ctl,
    output logic signed [SUM_W-1:0]           sum,
    output chmt_ctl_t                         exc_ctl,
    output logic signed [EXC_W-1:0]           excess,
    output logic                              busy
);

    localparam int PROD_W = 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] nrm_w [MAX_DIM];
    logic signed [COORD_BITS-1:0] vec_w [MAX_DIM];
    logic signed [PROD_W-1:0]     prod_next [MAX_DIM];
    logic signed [PROD_W-1:0]     prod_reg  [MAX_DIM];
    logic signed [OFS_W-1:0]      offset_p_reg;
    logic signed [OFS_W-1:0]      offset_s_reg;
    logic signed [SUM_W-1:0]      sum_next;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [EXC_W-1:0]      excess_next;
    logic signed [EXC_W-1:0]      excess_reg;
    chmt_ctl_t                    p_ctl_reg;
    chmt_ctl_t                    s_ctl_reg;
    chmt_ctl_t                    e_ctl_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_DIM; j++)
        begin
            nrm_w[j] = $signed(normal[j*COORD_BITS +: COORD_BITS]);
            vec_w[j] = $signed(vec[j*COORD_BITS +: COORD_BITS]);
            prod_next[j] = '0;
            if (dim_mask[j])
            begin
                prod_next[j] = nrm_w[j] * vec_w[j];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < MAX_DIM; j++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[j]);
        end
    end

    assign excess_next = EXC_W'(sum_reg) - EXC_W'(offset_s_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
            s_ctl_reg <= '0;
            e_ctl_reg <= '0;
        end
        else
        begin
            p_ctl_reg <= in_ctl;
            s_ctl_reg <= p_ctl_reg;
            e_ctl_reg <= s_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_DIM; j++)
        begin
            prod_reg[j] <= prod_next[j];
        end
        offset_p_reg <= offset;
        offset_s_reg <= offset_p_reg;
        sum_reg      <= sum_next;
        excess_reg   <= excess_next;
    end

    assign sum_ctl = s_ctl_reg;
    assign sum     = sum_reg;
    assign exc_ctl = e_ctl_reg;
    assign excess  = excess_reg;
    assign busy    = p_ctl_reg.valid | s_ctl_reg.valid | e_ctl_reg.valid;

endmodule

FILE: rtl/convex_hull_membership_test_unit.sv
// ----------------------------------------------------------------------------
// convex_hull_membership_test_unit
// Point-in-convex-polytope test against a table of facet half-spaces.
//
// Channel   Ports                                   Transfer
// command   start, busy, op, facet, coord0..coord3  start & !busy
// result    done, inside_res, distance              done (one cycle)
// config    APB psel/penable/pwrite/paddr/pwdata    psel & penable & pwrite
//
// Normal write: taken at the command edge.
// Vertex write: offset stored from the product sum after the walk, table read,
// product and sum registers; busy while walk, read or dot pipeline hold it.
// Query: done rises once all facets in use, facet_count capped at the table
// depth, have passed one per cycle through the single table read port and the
// dot-product pipeline; with no facets in use done rises the next cycle.
// Reset clears control state and loads register defaults; the facet tables
// hold no reset value. Results cannot be stalled.
// ----------------------------------------------------------------------------
module convex_hull_membership_test_unit
    import chmt_pkg::*;
#(
    parameter int MAX_FACETS = MAX_FACETS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [3:0]                   facet,
    input  logic signed [COORD_BITS-1:0] coord0,
    input  logic signed [COORD_BITS-1:0] coord1,
    input  logic signed [COORD_BITS-1:0] coord2,
    input  logic signed [COORD_BITS-1:0] coord3,
    output logic                         done,
    output logic                         inside_res,
    output logic [DIST_W-1:0]            distance,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int FIDX_W = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
    localparam int CNT_W  = $clog2(MAX_FACETS + 1);
    localparam int VEC_W  = MAX_DIM * COORD_BITS;
    localparam int SUM_W  = sum_width(COORD_BITS);
    localparam int EXC_W  = exc_width(COORD_BITS);

    logic [2:0] dimension_reg;
    logic [4:0] facet_count_reg;
    logic [7:0] tolerance_reg;
    logic       report_dist_reg;
    logic       cfg_wr;

    logic [VEC_W-1:0] normal_mem [MAX_FACETS];
    logic [OFS_W-1:0] offset_mem [MAX_FACETS];

    logic [COORD_BITS-1:0] coord_w [4];
    logic [VEC_W-1:0]      vec_pack;
    logic [VEC_W-1:0]      vec_reg;
    logic [MAX_DIM-1:0]    dim_mask;
    logic [CNT_W-1:0]      nf;
    logic                  facet_ok;
    logic                  accept;

    logic                  walk_reg;
    logic                  walk_query_reg;
    logic [CNT_W-1:0]      walk_idx_reg;
    logic [CNT_W-1:0]      nf_reg;
    logic [FIDX_W-1:0]     op_facet_reg;
    logic                  walk_last;

    chmt_ctl_t             ctl_r_reg;
    logic [VEC_W-1:0]      normal_rd_reg;
    logic [OFS_W-1:0]      offset_rd_reg;

    chmt_ctl_t               sum_ctl;
    logic signed [SUM_W-1:0] dot_sum;
    logic [63:0]             sum64;
    chmt_ctl_t               exc_ctl;
    logic signed [EXC_W-1:0] excess;
    logic                    dot_busy;

    logic                    outside_reg;
    logic signed [EXC_W-1:0] best_reg;
    logic                    hit;
    logic                    outside_next;
    logic signed [EXC_W-1:0] best_next;
    logic [63:0]             best64;
    logic [DIST_W-1:0]       dist_sat;

    logic                    done_reg;
    logic                    inside_reg;
    logic [DIST_W-1:0]       distance_reg;
    logic                    done_next;
    logic                    inside_next;
    logic [DIST_W-1:0]       distance_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg   <= DIMENSION_RST;
            facet_count_reg <= FACET_COUNT_RST;
            tolerance_reg   <= TOLERANCE_RST;
            report_dist_reg <= REPORT_DIST_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DIMENSION:   dimension_reg   <= pwdata[2:0];
                REG_FACET_COUNT: facet_count_reg <= pwdata[4:0];
                REG_TOLERANCE:   tolerance_reg   <= pwdata[7:0];
                REG_REPORT_DIST: report_dist_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIMENSION:   prdata = 32'(dimension_reg);
            REG_FACET_COUNT: prdata = 32'(facet_count_reg);
            REG_TOLERANCE:   prdata = 32'(tolerance_reg);
            REG_REPORT_DIST: prdata = 32'(report_dist_reg);
            default:         prdata = '0;
        endcase
    end

    // command decode
    assign coord_w[0] = coord0;
    assign coord_w[1] = coord1;
    assign coord_w[2] = coord2;
    assign coord_w[3] = coord3;

    always_comb
    begin
        for (int j = 0; j < MAX_DIM; j++)
        begin
            vec_pack[j*COORD_BITS +: COORD_BITS] = coord_w[j];
        end
    end

    always_comb
    begin
        int dims_use;
        dims_use = (int'(dimension_reg) > MAX_DIM) ? MAX_DIM : int'(dimension_reg);
        for (int j = 0; j < MAX_DIM; j++)
        begin
            dim_mask[j] = (j < dims_use);
        end
    end

    assign nf = (int'(facet_count_reg) > MAX_FACETS) ? CNT_W'(MAX_FACETS)
                                                     : CNT_W'(facet_count_reg);
    assign facet_ok = (int'(facet) < MAX_FACETS);
    assign busy     = walk_reg | ctl_r_reg.valid | dot_busy;
    assign accept   = start & ~busy;

    // facet walk
    assign walk_last = ~walk_query_reg | (walk_idx_reg == CNT_W'(nf_reg - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= 1'b0;
            walk_query_reg <= 1'b0;
            walk_idx_reg   <= '0;
            nf_reg         <= '0;
            op_facet_reg   <= '0;
        end
        else if (accept && op == OP_QUERY && nf != '0)
        begin
            walk_reg       <= 1'b1;
            walk_query_reg <= 1'b1;
            walk_idx_reg   <= '0;
            nf_reg         <= nf;
        end
        else if (accept && op == OP_VERTEX && facet_ok)
        begin
            walk_reg       <= 1'b1;
            walk_query_reg <= 1'b0;
            walk_idx_reg   <= CNT_W'(facet);
            op_facet_reg   <= FIDX_W'(facet);
        end
        else if (walk_reg)
        begin
            if (walk_last)
            begin
                walk_reg <= 1'b0;
            end
            else
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_QUERY || op == OP_VERTEX))
        begin
            vec_reg <= vec_pack;
        end
    end

    // facet tables
    assign sum64 = 64'(dot_sum);

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_NORMAL && facet_ok)
        begin
            normal_mem[FIDX_W'(facet)] <= vec_pack;
        end
        if (sum_ctl.valid && !sum_ctl.query)
        begin
            offset_mem[op_facet_reg] <= sum64[OFS_W-1:0];
        end
        normal_rd_reg <= normal_mem[walk_idx_reg[FIDX_W-1:0]];
        offset_rd_reg <= offset_mem[walk_idx_reg[FIDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_r_reg <= '0;
        end
        else
        begin
            ctl_r_reg.valid <= walk_reg;
            ctl_r_reg.last  <= walk_last;
            ctl_r_reg.query <= walk_query_reg;
        end
    end

    chmt_dot #(
        .MAX_DIM    (MAX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl_r_reg),
        .normal   (normal_rd_reg),
        .vec      (vec_reg),
        .offset   ($signed(offset_rd_reg)),
        .dim_mask (dim_mask),
        .sum_ctl  (sum_ctl),
        .sum      (dot_sum),
        .exc_ctl  (exc_ctl),
        .excess   (excess),
        .busy     (dot_busy)
    );

    // excess accumulation and result
    assign hit          = exc_ctl.valid & exc_ctl.query
                        & (excess >= $signed({1'b0, tolerance_reg}));
    assign outside_next = outside_reg | hit;
    assign best_next    = (hit && excess > best_reg) ? excess : best_reg;
    assign best64       = 64'($unsigned(best_next));
    assign dist_sat     = (best64 > 64'(DIST_MAX)) ? DIST_MAX : best64[DIST_W-1:0];

    always_comb
    begin
        done_next     = 1'b0;
        inside_next   = inside_reg;
        distance_next = distance_reg;
        if (accept && op == OP_QUERY && nf == '0)
        begin
            done_next     = 1'b1;
            inside_next   = 1'b1;
            distance_next = '0;
        end
        else if (exc_ctl.valid && exc_ctl.query && exc_ctl.last)
        begin
            done_next     = 1'b1;
            inside_next   = ~outside_next;
            distance_next = (outside_next && report_dist_reg) ? dist_sat : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (accept && op == OP_QUERY)
            begin
                outside_reg <= 1'b0;
            end
            else if (exc_ctl.valid && exc_ctl.query)
            begin
                outside_reg <= outside_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_QUERY)
        begin
            best_reg <= '0;
        end
        else if (exc_ctl.valid && exc_ctl.query)
        begin
            best_reg <= best_next;
        end
        inside_reg   <= inside_next;
        distance_reg <= distance_next;
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign distance   = distance_reg;

`ifndef SYNTHESIS
    a_inside_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        done && inside_res |-> distance == '0)
        else $error("inside result carries a nonzero distance");

    a_report_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && !report_dist_reg |-> distance == '0)
        else $error("distance reported while reporting is off");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        exc_ctl.valid && exc_ctl.query && exc_ctl.last |=> done)
        else $error("last facet of a query gave no result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dot_busy |-> busy)
        else $error("command taken while the pipeline holds facets");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: convex hull membership test unit testbench
// Drives facet normal writes, reference vertex writes, point queries and the
// unused op code through the start/busy command port, and programs all four
// registers over APB between phases. An internal half-space model of the
// facet tables predicts every query verdict, and a monitor compares each done
// strobe against the oldest pending verdict. Directed items cover a unit box
// hull, zero tolerance on a face, coordinate extremes and stale offsets. The
// random phases rebuild a box hull and then mix queries near it with noise,
// under extreme and random register settings, with and without idle bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import chmt_pkg::*;

    localparam int  CW          = COORD_BITS_DEF;
    localparam int  NFACET      = MAX_FACETS_DEF;
    localparam int  NDIM        = MAX_DIM_DEF;
    localparam int  IDLE_PAUSE  = 24;
    localparam int  END_PAUSE   = 40;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint DIST_CAP = (64'sd1 <<< DIST_W) - 1;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [NDIM-1:0][CW-1:0] point_t;

    typedef struct packed {
        logic              in_hull;
        logic [DIST_W-1:0] dist_val;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] op;
    logic [3:0] facet;
    logic signed [CW-1:0] coord0;
    logic signed [CW-1:0] coord1;
    logic signed [CW-1:0] coord2;
    logic signed [CW-1:0] coord3;
    logic done;
    logic inside_res;
    logic [DIST_W-1:0] distance;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    point_t normal_tab [NFACET];
    logic signed [OFS_W-1:0] offset_tab [NFACET];
    logic [2:0] dim_r   = DIMENSION_RST;
    logic [4:0] fcnt_r  = FACET_COUNT_RST;
    logic [7:0] tol_r   = TOLERANCE_RST;
    logic       rdist_r = REPORT_DIST_RST;

    verdict_t verdict_q [$];
    verdict_t got_v;
    int err_cnt    = 0;
    int cmd_cnt    = 0;
    int result_cnt = 0;
    int cfg_cnt    = 0;
    int cycle_cnt  = 0;

    convex_hull_membership_test_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .facet      (facet),
        .coord0     (coord0),
        .coord1     (coord1),
        .coord2     (coord2),
        .coord3     (coord3),
        .done       (done),
        .inside_res (inside_res),
        .distance   (distance),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_cnt++;
    endtask

    // ---------------- half-space model ----------------

    function automatic longint facet_dot(input int f, input point_t v);
        longint acc;
        int n;
        acc = 0;
        n = (dim_r > NDIM) ? NDIM : int'(dim_r);
        for (int j = 0; j < n; j++)
            acc += longint'($signed(normal_tab[f][j])) * longint'($signed(v[j]));
        return acc;
    endfunction

    function automatic verdict_t test_membership(input point_t v);
        verdict_t r;
        longint ex;
        longint best;
        int nf;
        logic outside;
        nf = (fcnt_r > NFACET) ? NFACET : int'(fcnt_r);
        outside = 1'b0;
        best = 0;
        for (int i = 0; i < nf; i++)
        begin
            ex = facet_dot(i, v) - longint'(offset_tab[i]);
            if (ex >= longint'(tol_r))
            begin
                outside = 1'b1;
                if (ex > best)
                    best = ex;
            end
        end
        r.in_hull = !outside;
        r.dist_val = '0;
        if (outside && rdist_r)
            r.dist_val = (best > DIST_CAP) ? DIST_MAX : best[DIST_W-1:0];
        return r;
    endfunction

    task automatic record_command(input logic [1:0] o, input logic [3:0] f, input point_t v);
        longint d;
        case (o)
            OP_NORMAL: normal_tab[f] = v;
            OP_VERTEX:
            begin
                d = facet_dot(f, v);
                offset_tab[f] = d[OFS_W-1:0];
            end
            OP_QUERY: verdict_q.push_back(test_membership(v));
            default: ;
        endcase
    endtask

    function automatic logic [31:0] reg_image(input logic [1:0] r);
        case (r)
            REG_DIMENSION:   return 32'(dim_r);
            REG_FACET_COUNT: return 32'(fcnt_r);
            REG_TOLERANCE:   return 32'(tol_r);
            default:         return 32'(rdist_r);
        endcase
    endfunction

    // ---------------- result monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_cnt++;
            if (verdict_q.size() == 0)
                report_mismatch("query result with no pending query");
            else
            begin
                got_v = verdict_q.pop_front();
                if (inside_res !== got_v.in_hull)
                    report_mismatch($sformatf("inside_res got %b want %b",
                                              inside_res, got_v.in_hull));
                if (distance !== got_v.dist_val)
                    report_mismatch($sformatf("distance got %0h want %0h",
                                              distance, got_v.dist_val));
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_cmd(input logic [1:0] o, input logic [3:0] f, input point_t v);
        start  <= 1'b1;
        op     <= o;
        facet  <= f;
        coord0 <= v[0];
        coord1 <= v[1];
        coord2 <= v[2];
        coord3 <= v[3];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        record_command(o, f, v);
        cmd_cnt++;
    endtask

    task automatic cmd_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap(input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
            cmd_gap($urandom_range(1, 16));
    endtask

    task automatic apb_write(input logic [1:0] r, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (r)
            REG_DIMENSION:   dim_r   = val[2:0];
            REG_FACET_COUNT: fcnt_r  = val[4:0];
            REG_TOLERANCE:   tol_r   = val[7:0];
            default:         rdist_r = val[0];
        endcase
        cfg_cnt++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [1:0] r, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // drop start, wait out pending verdicts, then let vertex writes settle
    task automatic drain_idle();
        start <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic set_config(input int d, input int c, input int t, input int rd);
        drain_idle();
        apb_write(REG_DIMENSION, 32'(d));
        apb_write(REG_FACET_COUNT, 32'(c));
        apb_write(REG_TOLERANCE, 32'(t));
        apb_write(REG_REPORT_DIST, 32'(rd));
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic point_t mk_point(input logic [CW-1:0] c0, input logic [CW-1:0] c1,
                                        input logic [CW-1:0] c2, input logic [CW-1:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CW-1:0] near_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom_range(0, 16'h8000)) - 16'h4000;
        endcase
    endfunction

    function automatic point_t random_point(input bit near);
        point_t p;
        for (int j = 0; j < NDIM; j++)
            p[j] = near ? near_coord() : rand_coord();
        return p;
    endfunction

    // axis-aligned box with random scales and slight random tilts on some facets
    task automatic build_box(input bit gaps);
        int axis;
        logic [CW-1:0] sc;
        logic [CW-1:0] h;
        point_t nrm;
        point_t vtx;
        for (int k = 0; k < NFACET; k++)
        begin
            axis = k % NDIM;
            sc = 16'($urandom_range(1, 16'h7fff));
            h  = 16'($urandom_range(16'h100, 16'h3000));
            nrm = '0;
            vtx = '0;
            for (int j = 0; j < NDIM; j++)
                if (j != axis && $urandom_range(0, 3) == 0)
                    nrm[j] = 16'($urandom_range(0, 16'h200)) - 16'h100;
            nrm[axis] = ((k / NDIM) % 2 == 1) ? -sc : sc;
            vtx[axis] = ((k / NDIM) % 2 == 1) ? -h : h;
            send_cmd(OP_NORMAL, 4'(k), nrm);
            maybe_gap(gaps);
            send_cmd(OP_VERTEX, 4'(k), vtx);
            maybe_gap(gaps);
        end
    endtask

    task automatic run_traffic(input int n, input bit gaps);
        int sent;
        int pick;
        logic [1:0] o;
        point_t v;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                o = OP_NORMAL;
                v = random_point(1'b0);
            end
            else if (pick < 22)
            begin
                o = OP_VERTEX;
                v = random_point(1'b0);
            end
            else if (pick < 26)
            begin
                o = OP_UNUSED;
                v = random_point(1'b0);
            end
            else
            begin
                o = OP_QUERY;
                v = random_point(pick < 86);
            end
            send_cmd(o, 4'($urandom_range(0, NFACET - 1)), v);
            if (o != OP_UNUSED)
                sent++;
            maybe_gap(gaps);
        end
    endtask

    // ---------------- tests ----------------

    task automatic check_register(input logic [1:0] r);
        logic [31:0] got;
        apb_read(r, got);
        if (got !== reg_image(r))
            report_mismatch($sformatf("reg %0d reads %0h want %0h", r, got, reg_image(r)));
        apb_write(r, $urandom);
        apb_read(r, got);
        if (got !== reg_image(r))
            report_mismatch($sformatf("reg %0d reads %0h want %0h", r, got, reg_image(r)));
    endtask

    task automatic test_register_access();
        check_register(REG_DIMENSION);
        check_register(REG_FACET_COUNT);
        check_register(REG_TOLERANCE);
        check_register(REG_REPORT_DIST);
    endtask

    // unit box in four dimensions, faces at +-1.0
    task automatic test_unit_box();
        point_t p;
        set_config(4, 8, 0, 1);
        for (int k = 0; k < 8; k++)
        begin
            p = '0;
            p[k % NDIM] = (k < NDIM) ? 16'h1000 : 16'hf000;
            send_cmd(OP_NORMAL, 4'(k), p);
            send_cmd(OP_VERTEX, 4'(k), p);
        end
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // on the face with zero tolerance: outside at zero distance
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h1000, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h0800, 16'hf800, 16'h0800, 16'hf800));
        send_cmd(OP_UNUSED, 4'hf, mk_point(16'h8000, 16'h7fff, 16'hffff, 16'h0000));
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h8000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // offset keeps the normal of its vertex write, not a later normal
    task automatic test_stale_offset();
        send_cmd(OP_NORMAL, 4'd1, mk_point(16'h0000, 16'h2000, 16'h0000, 16'h0000));
        send_cmd(OP_VERTEX, 4'd1, mk_point(16'h0000, 16'h1000, 16'h0000, 16'h0000));
        send_cmd(OP_NORMAL, 4'd1, mk_point(16'h0000, 16'h1000, 16'h0000, 16'h0000));
        send_cmd(OP_QUERY, 4'd0, mk_point(16'h0000, 16'h1800, 16'h0000, 16'h0000));
    endtask

    task automatic test_extreme_settings();
        set_config(4, 16, 0, 1);
        build_box(1'b1);
        run_traffic(30, 1'b1);
        set_config(1, 1, 255, 0);
        build_box(1'b1);
        run_traffic(30, 1'b1);
        set_config(0, 0, 128, 1);
        build_box(1'b1);
        run_traffic(30, 1'b1);
        set_config(7, 31, 1, 1);
        build_box(1'b1);
        run_traffic(30, 1'b1);
        set_config(5, 17, 255, 1);
        build_box(1'b1);
        run_traffic(30, 1'b1);
        set_config(2, 8, 3, 0);
        build_box(1'b1);
        run_traffic(30, 1'b1);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            set_config($urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 255), $urandom_range(0, 1));
            build_box(1'b1);
            run_traffic(30, 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        set_config(4, 16, 2, 1);
        build_box(1'b0);
        run_traffic(80, 1'b0);
    endtask

    // ---------------- sequencing ----------------

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        op      <= OP_NORMAL;
        facet   <= '0;
        coord0  <= '0;
        coord1  <= '0;
        coord2  <= '0;
        coord3  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_register_access();
        test_unit_box();
        test_stale_offset();
        test_extreme_settings();
        test_random_settings();
        test_back_to_back();

        start <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (END_PAUSE) @(posedge clk);

        $display("Covered %0d commands, %0d query results, %0d register writes",
                 cmd_cnt, result_cnt, cfg_cnt);
        $display("Settings spanned dimension 0..7, facet count 0..31, tolerance 0..255");
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d verdicts pending", cycle_cnt, verdict_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: convex_hull_membership_test_unit.f
rtl/chmt_pkg.sv
rtl/chmt_dot.sv
rtl/convex_hull_membership_test_unit.sv
sim/tb_top.sv
